@@ hdl/dihedral_angle_from_bonds_macros.svh @@
// Assertion macros used by the top-level datapath file.
`ifndef DIHEDRAL_ANGLE_FROM_BONDS_MACROS_SVH
`define DIHEDRAL_ANGLE_FROM_BONDS_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define DAB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define DAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

@@ hdl/dab_pkg.sv @@
`timescale 1ns / 1ps
package dab_pkg;
    localparam int CoordWidth   = 16;
    localparam int AngleWidth   = 16;
    localparam int CordicStages = 18;
    localparam int CordicWidth  = 34;
    localparam int AtanEntries  = 40;
    // One cell for each result bit of the 64-bit square root.
    localparam int SqrtCells    = 32;
    // Pipeline depth ahead of the CORDIC cells: four front stages, the root
    // cells and four stages for the sine product, normalisation and folding.
    localparam int FrontDepth   = SqrtCells + 8;
    localparam int Depth        = FrontDepth + CordicStages + 1;

    typedef logic signed [CordicWidth-1:0] t_cw;

    typedef struct packed {
        logic                  vld;
        logic                  degen;
        t_cw                   x;
        t_cw                   y;
        logic [31:0]           acc;
    } t_cordic;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] tab [0:AtanEntries-1];
        tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
                32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
                32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
                32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
                32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
                32'h00000001, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
        if (i < AtanEntries) begin
            return tab[i];
        end
        return 32'h0;
    endfunction
endpackage

@@ hdl/dab_if.sv @@
`timescale 1ns / 1ps
interface dab_in_if import dab_pkg::*; ();
    logic valid;
    logic ready;
    logic signed [CoordWidth-1:0] bond1_x, bond1_y, bond1_z;
    logic signed [CoordWidth-1:0] bond2_x, bond2_y, bond2_z;
    logic signed [CoordWidth-1:0] bond3_x, bond3_y, bond3_z;
    modport source (output valid, bond1_x, bond1_y, bond1_z, bond2_x, bond2_y, bond2_z,
                    bond3_x, bond3_y, bond3_z, input ready);
    modport sink (input valid, bond1_x, bond1_y, bond1_z, bond2_x, bond2_y, bond2_z,
                  bond3_x, bond3_y, bond3_z, output ready);
endinterface

interface dab_out_if import dab_pkg::*; ();
    logic valid;
    logic ready;
    logic [AngleWidth-1:0] torsion_angle;
    logic degenerate;
    modport source (output valid, torsion_angle, degenerate, input ready);
    modport sink (input valid, torsion_angle, degenerate, output ready);
endinterface

@@ hdl/dab_sqrt_cell.sv @@
`timescale 1ns / 1ps
// One step of a restoring square root: one result bit per cell.
module dab_sqrt_cell import dab_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [5:0]  i_step,
    input  logic [63:0] i_rem,
    input  logic [63:0] i_res,
    output logic [63:0] o_rem,
    output logic [63:0] o_res
);
    logic [63:0] w_bit;
    logic [63:0] r_rem, r_res;
    assign w_bit = 64'd1 << (7'd62 - {i_step, 1'b0});
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_rem >= i_res + w_bit) begin
                r_rem <= i_rem - (i_res + w_bit);
                r_res <= (i_res >> 1) + w_bit;
            end else begin
                r_rem <= i_rem;
                r_res <= i_res >> 1;
            end
        end
    end
    assign o_rem = r_rem;
    assign o_res = r_res;
endmodule

@@ hdl/dab_cordic_cell.sv @@
`timescale 1ns / 1ps
// One vectoring CORDIC micro-rotation with a fixed shift.
module dab_cordic_cell import dab_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic [5:0] i_idx,
    input  t_cordic i_d,
    output t_cordic o_d
);
    t_cordic r_d;
    t_cw w_dx, w_dy;
    logic [31:0] w_at;
    assign w_dx = i_d.y >>> i_idx;
    assign w_dy = i_d.x >>> i_idx;
    assign w_at = atan_turn(int'(i_idx));
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else if (i_en) begin
            r_d.vld <= i_d.vld;
        end
        if (i_en) begin
            r_d.degen <= i_d.degen;
            if (i_d.y > 0) begin
                r_d.x <= i_d.x + w_dx; r_d.y <= i_d.y - w_dy; r_d.acc <= i_d.acc + w_at;
            end else begin
                r_d.x <= i_d.x - w_dx; r_d.y <= i_d.y + w_dy; r_d.acc <= i_d.acc - w_at;
            end
        end
    end
    assign o_d = r_d;
endmodule

@@ hdl/dihedral_angle_from_bonds.sv @@
`timescale 1ns / 1ps
// Channel   | Direction | Payload
// s_in      | sink      | bond1..bond3 x/y/z, signed 16 bit
// m_out     | source    | torsion_angle 16 bit, degenerate
// One transfer is accepted every cycle while the output is not stalled; the pipeline
// has Depth = 59 register stages: four front stages, the 32-cell square root chain,
// four stages for the sine product and normalisation, the 18 CORDIC cells and the
// output.
// Reset clears only the valid bits of the pipeline.
// A stall on the output freezes the whole pipeline; ready is high whenever the
// output register is empty or being emptied.
`include "dihedral_angle_from_bonds_macros.svh"
module dihedral_angle_from_bonds import dab_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    dab_in_if.sink    s_in,
    dab_out_if.source m_out
);
    // The pipeline advances whenever the output stage can move.
    logic w_en;
    assign w_en = !m_out.valid || m_out.ready;
    assign s_in.ready = w_en;

    // Stage 1: products for cross products.
    logic r1_v;
    logic signed [31:0] r1_p [0:11];
    logic signed [15:0] r1_b [0:2], r1_c [0:2];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0; else if (w_en) r1_v <= s_in.valid;
        if (w_en) begin
            r1_p[0]  <= s_in.bond1_y * s_in.bond2_z; r1_p[1]  <= s_in.bond1_z * s_in.bond2_y;
            r1_p[2]  <= s_in.bond1_z * s_in.bond2_x; r1_p[3]  <= s_in.bond1_x * s_in.bond2_z;
            r1_p[4]  <= s_in.bond1_x * s_in.bond2_y; r1_p[5]  <= s_in.bond1_y * s_in.bond2_x;
            r1_p[6]  <= s_in.bond2_y * s_in.bond3_z; r1_p[7]  <= s_in.bond2_z * s_in.bond3_y;
            r1_p[8]  <= s_in.bond2_z * s_in.bond3_x; r1_p[9]  <= s_in.bond2_x * s_in.bond3_z;
            r1_p[10] <= s_in.bond2_x * s_in.bond3_y; r1_p[11] <= s_in.bond2_y * s_in.bond3_x;
            r1_b[0] <= s_in.bond2_x; r1_b[1] <= s_in.bond2_y; r1_b[2] <= s_in.bond2_z;
            r1_c[0] <= s_in.bond3_x; r1_c[1] <= s_in.bond3_y; r1_c[2] <= s_in.bond3_z;
        end
    end

    // Stage 2: the cross products n1 and n2, 33 bits each.
    logic r2_v;
    logic signed [32:0] r2_n1 [0:2], r2_n2 [0:2];
    logic signed [15:0] r2_b [0:2], r2_c [0:2];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0; else if (w_en) r2_v <= r1_v;
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r2_n1[i] <= 33'(r1_p[2*i]) - 33'(r1_p[2*i+1]);
                r2_n2[i] <= 33'(r1_p[6+2*i]) - 33'(r1_p[7+2*i]);
                r2_b[i] <= r1_b[i]; r2_c[i] <= r1_c[i];
            end
        end
    end

    // Stage 3: the degenerate flag, the element products of the dot products and |b2|^2 terms.
    logic r3_v, r3_dg;
    logic signed [65:0] r3_cp [0:2];
    logic signed [49:0] r3_tp [0:2];
    logic [31:0] r3_bb [0:2];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0; else if (w_en) r3_v <= r2_v;
        if (w_en) begin
            r3_dg <= (r2_n1[0] == 0 && r2_n1[1] == 0 && r2_n1[2] == 0) ||
                     (r2_n2[0] == 0 && r2_n2[1] == 0 && r2_n2[2] == 0);
            for (int i = 0; i < 3; i++) begin
                r3_cp[i] <= 66'(r2_n1[i]) * 66'(r2_n2[i]);
                r3_tp[i] <= 50'(r2_n1[i]) * 50'(r2_c[i]);
                r3_bb[i] <= 32'(r2_b[i] * r2_b[i]);
            end
        end
    end

    // Stage 4: sums, magnitudes and signs.
    logic r4_v, r4_dg, r4_cs, r4_ts;
    logic [66:0] r4_cm;
    logic [51:0] r4_tm;
    logic [63:0] r4_len;
    logic signed [67:0] w_c;
    logic signed [51:0] w_t;
    assign w_c = 68'(r3_cp[0]) + 68'(r3_cp[1]) + 68'(r3_cp[2]);
    assign w_t = 52'(r3_tp[0]) + 52'(r3_tp[1]) + 52'(r3_tp[2]);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0; else if (w_en) r4_v <= r3_v;
        if (w_en) begin
            r4_dg  <= r3_dg;
            r4_cs  <= w_c[67];
            r4_ts  <= w_t[51];
            r4_cm  <= 67'(w_c[67] ? -w_c : w_c);
            r4_tm  <= w_t[51] ? 52'(-w_t) : 52'(w_t);
            r4_len <= (64'(r3_bb[0]) + 64'(r3_bb[1]) + 64'(r3_bb[2])) << 30;
        end
    end

    // Square root chain: 32 cells, the side data travels alongside.
    logic [63:0] w_rem [0:SqrtCells], w_res [0:SqrtCells];
    logic        r_sv [1:SqrtCells], r_sdg [1:SqrtCells], r_scs [1:SqrtCells];
    logic        r_sts [1:SqrtCells];
    logic [66:0] r_scm [1:SqrtCells];
    logic [51:0] r_stm [1:SqrtCells];
    assign w_rem[0] = r4_len;
    assign w_res[0] = 64'd0;
    for (genvar g = 0; g < SqrtCells; g++) begin : g_sq
        dab_sqrt_cell u_cell (
            .i_clk(i_clk), .i_en(w_en), .i_step(6'(g)),
            .i_rem(w_rem[g]), .i_res(w_res[g]),
            .o_rem(w_rem[g+1]), .o_res(w_res[g+1])
        );
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= SqrtCells; i++) r_sv[i] <= 1'b0;
        end else if (w_en) begin
            r_sv[1] <= r4_v;
            for (int i = 2; i <= SqrtCells; i++) r_sv[i] <= r_sv[i-1];
        end
        if (w_en) begin
            r_sdg[1] <= r4_dg; r_scs[1] <= r4_cs; r_sts[1] <= r4_ts;
            r_scm[1] <= r4_cm; r_stm[1] <= r4_tm;
            for (int i = 2; i <= SqrtCells; i++) begin
                r_sdg[i] <= r_sdg[i-1]; r_scs[i] <= r_scs[i-1]; r_sts[i] <= r_sts[i-1];
                r_scm[i] <= r_scm[i-1]; r_stm[i] <= r_stm[i-1];
            end
        end
    end

    // Sine term: r times |t| split into two 32x26 partial products.
    logic r5_v, r5_dg, r5_cs, r5_ts;
    logic [66:0] r5_cm;
    logic [57:0] r5_plo, r5_phi;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0; else if (w_en) r5_v <= r_sv[SqrtCells];
        if (w_en) begin
            r5_dg <= r_sdg[SqrtCells]; r5_cs <= r_scs[SqrtCells]; r5_ts <= r_sts[SqrtCells];
            r5_cm <= r_scm[SqrtCells];
            r5_plo <= 58'(w_res[SqrtCells][31:0]) * 58'(r_stm[SqrtCells][25:0]);
            r5_phi <= 58'(w_res[SqrtCells][31:0]) * 58'(r_stm[SqrtCells][51:26]);
        end
    end

    logic r6_v, r6_dg, r6_cs, r6_ts;
    logic [83:0] r6_s, r6_c;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0; else if (w_en) r6_v <= r5_v;
        if (w_en) begin
            r6_dg <= r5_dg; r6_cs <= r5_cs; r6_ts <= r5_ts;
            r6_s  <= 84'(r5_plo) + (84'(r5_phi) << 26);
            r6_c  <= 84'(r5_cm) << 15;
        end
    end

    // Leading-one position of the larger magnitude.
    logic r7_v, r7_dg, r7_cs, r7_ts;
    logic [83:0] r7_s, r7_c;
    logic [6:0]  r7_bl;
    logic [83:0] w_or;
    logic [6:0]  w_bl;
    assign w_or = r6_s | r6_c;
    always_comb begin
        w_bl = 7'd0;
        for (int i = 0; i < 84; i++) if (w_or[i]) w_bl = 7'(i + 1);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0; else if (w_en) r7_v <= r6_v;
        if (w_en) begin
            r7_dg <= r6_dg; r7_cs <= r6_cs; r7_ts <= r6_ts;
            r7_s <= r6_s; r7_c <= r6_c; r7_bl <= w_bl;
        end
    end

    // Normalise to 30 bits, restore signs and fold into the right half plane.
    t_cordic w_c0, r8;
    logic [83:0] w_xm, w_ym;
    t_cw w_x, w_y;
    always_comb begin
        if (r7_bl > 7'd30) begin
            w_xm = r7_c >> (r7_bl - 7'd30);
            w_ym = r7_s >> (r7_bl - 7'd30);
        end else begin
            w_xm = r7_c << (7'd30 - r7_bl);
            w_ym = r7_s << (7'd30 - r7_bl);
        end
        w_x = r7_cs ? -t_cw'(w_xm[30:0]) : t_cw'(w_xm[30:0]);
        w_y = r7_ts ? -t_cw'(w_ym[30:0]) : t_cw'(w_ym[30:0]);
        w_c0.vld = r7_v;
        w_c0.degen = r7_dg;
        if (w_x < 0) begin
            w_c0.x = -w_x; w_c0.y = -w_y; w_c0.acc = 32'h80000000;
        end else begin
            w_c0.x = w_x; w_c0.y = w_y; w_c0.acc = 32'h0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8.vld <= 1'b0; else if (w_en) r8.vld <= w_c0.vld;
        if (w_en) begin
            r8.degen <= w_c0.degen; r8.x <= w_c0.x; r8.y <= w_c0.y; r8.acc <= w_c0.acc;
        end
    end

    // CORDIC cells.
    t_cordic w_cd [0:CordicStages];
    assign w_cd[0] = r8;
    for (genvar g = 0; g < CordicStages; g++) begin : g_cor
        dab_cordic_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_idx(6'(g)),
            .i_d(w_cd[g]), .o_d(w_cd[g+1])
        );
    end

    // Output register with rounding to the angle width.
    t_cordic w_last;
    logic [32:0] w_rnd;
    assign w_last = w_cd[CordicStages];
    assign w_rnd = 33'(w_last.acc) + 33'(33'd1 << (32 - AngleWidth - 1));
    logic r_ov;
    logic [AngleWidth-1:0] r_ang;
    logic r_dg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0; else if (w_en) r_ov <= w_last.vld;
        if (w_en) begin
            r_dg  <= w_last.degen;
            r_ang <= w_last.degen ? '0 : w_rnd[31 -: AngleWidth];
        end
    end
    assign m_out.valid = r_ov;
    assign m_out.torsion_angle = r_ang;
    assign m_out.degenerate = r_dg;

    `DAB_ASSERT_IMP(a_degen_zero, i_clk, i_rst_n, m_out.valid && m_out.degenerate, m_out.torsion_angle == '0)
    `DAB_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_out.valid && !m_out.ready, m_out.valid && $stable(m_out.torsion_angle))
    `DAB_ASSERT_IMP(a_ready, i_clk, i_rst_n, !m_out.valid, s_in.ready)
endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import dab_pkg::*;

    // The bonds of one torsion evaluation; the angle that they should give is a t_torsion.
    typedef struct {
        logic signed [CoordWidth-1:0] b1 [3];
        logic signed [CoordWidth-1:0] b2 [3];
        logic signed [CoordWidth-1:0] b3 [3];
    } t_bonds;

    typedef struct {
        logic [AngleWidth-1:0] angle;
        logic                  degen;
    } t_torsion;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dab_in_if  bonds_ch ();
    dab_out_if angle_ch ();

    dihedral_angle_from_bonds dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (bonds_ch.sink),
        .m_out   (angle_ch.source)
    );

    always #5 i_clk = ~i_clk;

    t_bonds   bonds_to_send [$];
    t_torsion angles_due [$];
    int       error_count = 0;
    int       sender_gap = 0;
    int       receiver_gap = 0;
    // Long hold-off of the receiver, counted down in its own process.
    int       hold_off = 0;
    // Set by the stimulus process to stop all idling for the last part of the run.
    bit       calm = 1'b0;
    // Set when the sender must wait for the pipeline to drain.
    bit       drain_pause = 1'b0;

    // Arctangent table in 2^-32 turn, written out again so the predictor stands alone.
    localparam logic [31:0] ArctanTurns [40] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};

    // Integer square root by bit pairs, floor of the true root.
    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Works out the torsion angle of one set of bonds. The cross products and
    // dot products are exact; the sine and cosine magnitudes are scaled to a
    // 30-bit mantissa and fed through a vectoring CORDIC.
    function automatic t_torsion torsion_of(input t_bonds bd);
        t_torsion res;
        longint a [3], b [3], c [3], n1 [3], n2 [3];
        longint t, x, y, dx, dy, p;
        logic [63:0] pos, neg, cmag, tmag, len2, rt;
        logic [127:0] sine_w, cos_w, larger;
        logic [31:0] acc;
        logic [32:0] rounded;
        logic [63:0] xm, ym;
        int nbits;
        for (int i = 0; i < 3; i++) begin
            a[i] = bd.b1[i];
            b[i] = bd.b2[i];
            c[i] = bd.b3[i];
        end
        n1[0] = a[1] * b[2] - a[2] * b[1];
        n1[1] = a[2] * b[0] - a[0] * b[2];
        n1[2] = a[0] * b[1] - a[1] * b[0];
        n2[0] = b[1] * c[2] - b[2] * c[1];
        n2[1] = b[2] * c[0] - b[0] * c[2];
        n2[2] = b[0] * c[1] - b[1] * c[0];
        if ((n1[0] == 0 && n1[1] == 0 && n1[2] == 0) ||
            (n2[0] == 0 && n2[1] == 0 && n2[2] == 0)) begin
            res.angle = '0;
            res.degen = 1'b1;
            return res;
        end
        pos = 0;
        neg = 0;
        for (int i = 0; i < 3; i++) begin
            p = n1[i] * n2[i];
            if (p >= 0) pos = pos + 64'(p);
            else neg = neg + 64'(-p);
        end
        cmag = (pos >= neg) ? pos - neg : neg - pos;
        t = n1[0] * c[0] + n1[1] * c[1] + n1[2] * c[2];
        tmag = (t >= 0) ? 64'(t) : 64'(-t);
        len2 = 64'(b[0] * b[0] + b[1] * b[1] + b[2] * b[2]);
        rt = root_floor(len2 << 30);
        sine_w = 128'(rt) * 128'(tmag);
        cos_w = 128'(cmag) << 15;
        larger = (cos_w > sine_w) ? cos_w : sine_w;
        nbits = 0;
        for (int i = 0; i < 128; i++) if (larger[i]) nbits = i + 1;
        if (nbits > 30) begin
            xm = 64'(cos_w >> (nbits - 30));
            ym = 64'(sine_w >> (nbits - 30));
        end else begin
            xm = 64'(cos_w << (30 - nbits));
            ym = 64'(sine_w << (30 - nbits));
        end
        x = (pos >= neg) ? longint'(xm) : -longint'(xm);
        y = (t >= 0) ? longint'(ym) : -longint'(ym);
        acc = '0;
        // A vector in the left half plane is first turned by half a turn.
        if (x < 0) begin
            x = -x;
            y = -y;
            acc = 32'h80000000;
        end
        for (int i = 0; i < CordicStages && i < 40; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                acc = acc + ArctanTurns[i];
            end else begin
                x = x - dx;
                y = y + dy;
                acc = acc - ArctanTurns[i];
            end
        end
        // Round half up; a value that reaches a full turn wraps to zero.
        rounded = ({1'b0, acc} + (33'd1 << (32 - AngleWidth - 1))) >> (32 - AngleWidth);
        res.angle = rounded[AngleWidth-1:0];
        res.degen = 1'b0;
        return res;
    endfunction

    function automatic t_bonds make_bonds(input longint v [9]);
        t_bonds bd;
        for (int i = 0; i < 3; i++) begin
            bd.b1[i] = CoordWidth'(v[i]);
            bd.b2[i] = CoordWidth'(v[3 + i]);
            bd.b3[i] = CoordWidth'(v[6 + i]);
        end
        return bd;
    endfunction

    function automatic logic signed [CoordWidth-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1: return $signed(16'($urandom_range(0, 15))) - 16'sd8;
            2: return $signed(16'($urandom_range(0, 1023))) - 16'sd512;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random bonds; some share a line so that the collinear case keeps turning up.
    function automatic t_bonds rand_bonds();
        t_bonds bd;
        int k;
        for (int i = 0; i < 3; i++) begin
            bd.b1[i] = rand_coord();
            bd.b2[i] = rand_coord();
            bd.b3[i] = rand_coord();
        end
        case ($urandom_range(0, 19))
            0: for (int i = 0; i < 3; i++) bd.b1[i] = bd.b2[i];
            1: for (int i = 0; i < 3; i++) bd.b3[i] = -bd.b2[i];
            2: begin
                k = $urandom_range(1, 3);
                for (int i = 0; i < 3; i++) begin
                    bd.b2[i] = $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
                    bd.b1[i] = CoordWidth'(bd.b2[i] * k);
                end
            end
            3: for (int i = 0; i < 3; i++) bd.b2[i] = '0;
            default: ;
        endcase
        return bd;
    endfunction

    // Driver: offers the oldest pending bonds, with random gaps while idling is on.
    // An accepted transfer is removed at once, so the front of the queue is always
    // the next one to offer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bonds_ch.valid <= 1'b0;
            sender_gap <= 0;
        end else begin
            if (bonds_ch.valid && bonds_ch.ready) begin
                void'(bonds_to_send.pop_front());
            end
            if (bonds_ch.valid && !bonds_ch.ready) begin
                // Hold the current transfer until it is taken.
            end else if (sender_gap > 0) begin
                sender_gap <= sender_gap - 1;
                bonds_ch.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                sender_gap <= $urandom_range(1, 13) - 1;
                bonds_ch.valid <= 1'b0;
            end else if (drain_pause) begin
                bonds_ch.valid <= 1'b0;
            end else if (bonds_to_send.size() > 0) begin
                t_bonds nxt;
                nxt = bonds_to_send[0];
                bonds_ch.valid <= 1'b1;
                {bonds_ch.bond1_x, bonds_ch.bond1_y, bonds_ch.bond1_z} <=
                    {nxt.b1[0], nxt.b1[1], nxt.b1[2]};
                {bonds_ch.bond2_x, bonds_ch.bond2_y, bonds_ch.bond2_z} <=
                    {nxt.b2[0], nxt.b2[1], nxt.b2[2]};
                {bonds_ch.bond3_x, bonds_ch.bond3_y, bonds_ch.bond3_z} <=
                    {nxt.b3[0], nxt.b3[1], nxt.b3[2]};
            end else begin
                bonds_ch.valid <= 1'b0;
            end
        end
    end

    // Every accepted transfer on the input is predicted at once.
    always @(posedge i_clk) begin
        if (i_rst_n && bonds_ch.valid && bonds_ch.ready) begin
            t_bonds seen;
            seen.b1 = '{bonds_ch.bond1_x, bonds_ch.bond1_y, bonds_ch.bond1_z};
            seen.b2 = '{bonds_ch.bond2_x, bonds_ch.bond2_y, bonds_ch.bond2_z};
            seen.b3 = '{bonds_ch.bond3_x, bonds_ch.bond3_y, bonds_ch.bond3_z};
            angles_due.push_back(torsion_of(seen));
        end
    end

    // Receiver: random stalls, and a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            angle_ch.ready <= 1'b0;
            receiver_gap <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            angle_ch.ready <= 1'b0;
        end else if (receiver_gap > 0) begin
            receiver_gap <= receiver_gap - 1;
            angle_ch.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            receiver_gap <= $urandom_range(1, 13) - 1;
            angle_ch.ready <= 1'b0;
        end else begin
            angle_ch.ready <= 1'b1;
        end
    end

    // Monitor: each result transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && angle_ch.valid && angle_ch.ready) begin
            if (angles_due.size() == 0) begin
                $display("%0t: result with nothing expected: angle %h degenerate %b",
                         $time, angle_ch.torsion_angle, angle_ch.degenerate);
                error_count++;
            end else begin
                t_torsion want;
                want = angles_due.pop_front();
                if (angle_ch.torsion_angle !== want.angle) begin
                    $display("%0t: torsion_angle expected %h actual %h",
                             $time, want.angle, angle_ch.torsion_angle);
                    error_count++;
                end
                if (angle_ch.degenerate !== want.degen) begin
                    $display("%0t: degenerate expected %b actual %b",
                             $time, want.degen, angle_ch.degenerate);
                    error_count++;
                end
            end
        end
    end

    initial begin
        longint v [9];
        bonds_ch.valid = 1'b0;
        {bonds_ch.bond1_x, bonds_ch.bond1_y, bonds_ch.bond1_z} = '0;
        {bonds_ch.bond2_x, bonds_ch.bond2_y, bonds_ch.bond2_z} = '0;
        {bonds_ch.bond3_x, bonds_ch.bond3_y, bonds_ch.bond3_z} = '0;
        angle_ch.ready = 1'b0;

        // Directed bonds: right angles of each sign, planar cis and trans,
        // the coordinate extremes, collinear bonds, a zero middle bond and
        // an angle just short of half a turn, which rounds up to half a turn.
        v = '{4096, 0, 0, 0, 4096, 0, 0, 0, 4096}; bonds_to_send.push_back(make_bonds(v));
        v = '{4096, 0, 0, 0, 4096, 0, 0, 0, -4096}; bonds_to_send.push_back(make_bonds(v));
        v = '{4096, 0, 0, 0, 4096, 0, -4096, 0, 0}; bonds_to_send.push_back(make_bonds(v));
        v = '{4096, 0, 0, 0, 4096, 0, 4096, 0, 0}; bonds_to_send.push_back(make_bonds(v));
        v = '{32767, -32768, 32767, -32768, 32767, 32767, 32767, 32767, -32768};
        bonds_to_send.push_back(make_bonds(v));
        v = '{-32768, -32768, -32768, 32767, -32768, 0, -32768, 32767, 32767};
        bonds_to_send.push_back(make_bonds(v));
        v = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}; bonds_to_send.push_back(make_bonds(v));
        v = '{32767, 32767, 32767, -32768, -32768, -32768, 1, 2, 3};
        bonds_to_send.push_back(make_bonds(v));
        v = '{1, 2, 3, 2, 4, 6, 5, 1, 0}; bonds_to_send.push_back(make_bonds(v));
        v = '{5, 1, 0, 2, 4, 6, -4, -8, -12}; bonds_to_send.push_back(make_bonds(v));
        v = '{5, 1, 0, 0, 0, 0, 3, 3, 3}; bonds_to_send.push_back(make_bonds(v));
        v = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; bonds_to_send.push_back(make_bonds(v));
        v = '{4096, 0, 0, 0, 4096, 0, 4096, 0, -1}; bonds_to_send.push_back(make_bonds(v));
        v = '{4096, 0, 0, 0, 4096, 0, 32767, 0, -1}; bonds_to_send.push_back(make_bonds(v));
        v = '{4096, 0, 0, 0, 4096, 0, 32767, 0, 1}; bonds_to_send.push_back(make_bonds(v));
        v = '{-1, -1, -1, 1, 0, 0, 0, 1, 0}; bonds_to_send.push_back(make_bonds(v));
        v = '{1, 0, 0, 0, 1, 0, -32768, -1, -32768}; bonds_to_send.push_back(make_bonds(v));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the directed part, then pause until the pipeline has drained.
        wait (bonds_to_send.size() == 0);
        @(posedge i_clk);
        drain_pause = 1'b1;
        wait (angles_due.size() == 0);
        drain_pause = 1'b0;

        // Random part, with a long receiver hold-off so that the pipeline fills.
        for (int i = 0; i < 900; i++) begin
            bonds_to_send.push_back(rand_bonds());
            if (i == 200) begin
                wait (bonds_to_send.size() < 20);
                @(posedge i_clk);
                hold_off = 3 * Depth + 40;
            end
            if (i == 700) begin
                // The last couple of hundred transfers run with no idling at all.
                wait (bonds_to_send.size() < 20);
                calm = 1'b1;
            end
        end
        wait (bonds_to_send.size() == 0);
        @(posedge i_clk);
        wait (angles_due.size() == 0);
        repeat (Depth + 20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Far beyond the slowest correct run: every transfer waiting out both sides' gaps.
    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
